### rtl/set_assoc_cache_tag_store_assert.svh
// Assertion macros shared by the tag store checkers
`ifndef SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define SACTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag store assertion failed");

// Next-cycle implication, off while reset is high
`define SACTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag store assertion failed");

// Next-cycle implication that also holds through reset
`define SACTS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tag store assertion failed");

`endif

### rtl/sacts_pkg.sv
// Types, sizes and tables of the set-associative tag store
`default_nettype none

package sacts_pkg;

  localparam int SETS = 256;
  localparam int WAYS = 4;

  localparam int ADDR_W = 31;
  localparam int TIME_W = 32;
  localparam int PICK_W = 8;
  localparam int WAYOUT_W = 8;
  localparam int ENT_W = ADDR_W + 1;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_P = 1 << WAY_W;

  // Reciprocal for the set reduction: quot = (addr * RECIP_M) >> RECIP_SH
  localparam int RECIP_SH = 31;
  localparam logic [31:0] RECIP_M = 32'((64'(1) << RECIP_SH) / SETS);

  localparam logic [1:0] REQ_LOOKUP     = 2'd0;
  localparam logic [1:0] REQ_ALLOC_LRU  = 2'd1;
  localparam logic [1:0] REQ_ALLOC_RAND = 2'd2;
  // Unused selector: no state change, all-zero result
  localparam logic [1:0] REQ_UNUSED     = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } tag_ent_t;

  typedef tag_ent_t [WAYS-1:0] tag_row_t;
  typedef logic [WAYS-1:0][TIME_W-1:0] stamp_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] lru_way;
  } sel_res_t;

  typedef logic [WAY_W-1:0] pick_rom_t [1 << PICK_W];

  function automatic pick_rom_t build_pick_rom();
    pick_rom_t rom;
    for (int i = 0; i < (1 << PICK_W); i++) begin
      rom[i] = WAY_W'(i % WAYS);
    end
    return rom;
  endfunction

  // Random pick reduced modulo the way count
  localparam pick_rom_t PICK_ROM = build_pick_rom();

endpackage

`default_nettype wire

### rtl/sacts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none

module sacts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/sacts_way_sel.sv
// Way search of one set: hit match, LRU pick and empty-way override
`default_nettype none

module sacts_way_sel
  import sacts_pkg::*;
(
  input  wire tag_row_t          tag_row,
  input  wire stamp_row_t        stamp_row,
  input  wire logic [ADDR_W-1:0] addr,
  output sel_res_t               sel
);

  logic [TIME_W-1:0] node_stamp [2*WAY_P-1];
  logic [WAY_W-1:0]  node_idx   [2*WAY_P-1];
  logic              found;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  lru_way;

  // First matching way
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && tag_row[i].valid && tag_row[i].addr == addr) begin
        found   = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
  end

  // Min tree; ties keep the left (lower) way, padding sits at the right
  always_comb begin
    for (int i = 0; i < WAY_P; i++) begin
      node_stamp[WAY_P-1+i] = (i < WAYS) ? stamp_row[i] : '1;
      node_idx[WAY_P-1+i]   = WAY_W'(i);
    end
    for (int n = WAY_P - 2; n >= 0; n--) begin
      if (node_stamp[2*n+2] < node_stamp[2*n+1]) begin
        node_stamp[n] = node_stamp[2*n+2];
        node_idx[n]   = node_idx[2*n+2];
      end else begin
        node_stamp[n] = node_stamp[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end
    end
    // Last empty way wins over the stamps
    lru_way = node_idx[0];
    for (int i = 0; i < WAYS; i++) begin
      if (!tag_row[i].valid) begin
        lru_way = WAY_W'(i);
      end
    end
  end

  assign sel = '{hit: found, hit_way: hit_way, lru_way: lru_way};

endmodule

`default_nettype wire

### rtl/set_assoc_cache_tag_store.sv
// Top level of the set-associative tag store with LRU and random replacement
//
//  channel | dir | tuser            | tdata
//  s_*     | in  | [1:0] req_type   | [30:0] block_addr, [62:31] access_time,
//          |     |                  | [70:63] random_pick, [71] zero
//  m_*     | out | [0] hit          | [7:0] way_used, [8] evicted_valid,
//          |     |                  | [39:9] evicted_addr
//
// Each request passes through accept, set-index reduction through the
// reciprocal multiplier, set row read, and one read-modify-write of the set.
// Tags and stamps each sit in a RAM of SETS rows holding a whole set.
// After reset a clearing pass writes SETS rows; s_tready is low.
// A result waits in the output register; the write-back holds until it drains.
`default_nettype none

module set_assoc_cache_tag_store
  import sacts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // block_addr, access_time, random_pick, pad
  input  wire logic [1:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // way_used, evicted_valid, evicted_addr
  output logic      [0:0]  m_tuser   // hit
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_SETI,
    ST_EXEC
  } state_t;

  state_t            state;
  logic [SET_W-1:0]  clr_idx;
  logic [1:0]        req_kind;
  logic [ADDR_W-1:0] req_addr;
  logic [TIME_W-1:0] req_time;
  logic [PICK_W-1:0] req_pick;
  logic [ADDR_W-1:0] quot;
  logic [SET_W-1:0]  set_idx;

  logic [ADDR_W-1:0] quot_next;
  logic [31:0]       rem_full;
  logic [31:0]       rem_fix;
  logic [SET_W-1:0]  set_calc;

  logic              tag_we;
  logic              stamp_we;
  logic [SET_W-1:0]  waddr;
  tag_row_t          tag_wdata;
  stamp_row_t        stamp_wdata;
  logic              rd_en;
  tag_row_t          tag_rd;
  stamp_row_t        stamp_rd;
  sel_res_t          sel;

  tag_row_t          tag_new;
  stamp_row_t        stamp_new;
  logic              tag_chg;
  logic              stamp_chg;
  logic              res_hit;
  logic [WAY_W-1:0]  res_way;
  logic              res_ev_valid;
  logic [ADDR_W-1:0] res_ev_addr;
  logic              done;

  assign s_tready = (state == ST_IDLE);
  assign done     = !m_tvalid || m_tready;

  // Set index = addr mod SETS: reciprocal estimate, then one correction
  assign quot_next = ADDR_W'((63'(req_addr) * 63'(RECIP_M)) >> RECIP_SH);
  assign rem_full  = 32'(req_addr) - 32'(quot) * 32'(SETS);
  assign rem_fix   = (rem_full >= 32'(SETS)) ? rem_full - 32'(SETS) : rem_full;
  assign set_calc  = rem_fix[SET_W-1:0];

  assign rd_en = (state == ST_SETI);

  sacts_ram #(
    .WIDTH (WAYS * ENT_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (waddr),
    .wdata (tag_wdata),
    .re    (rd_en),
    .raddr (set_calc),
    .rdata (tag_rd)
  );

  sacts_ram #(
    .WIDTH (WAYS * TIME_W),
    .DEPTH (SETS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (waddr),
    .wdata (stamp_wdata),
    .re    (rd_en),
    .raddr (set_calc),
    .rdata (stamp_rd)
  );

  sacts_way_sel u_way_sel (
    .tag_row   (tag_rd),
    .stamp_row (stamp_rd),
    .addr      (req_addr),
    .sel       (sel)
  );

  // Modify the set row for the request in hand
  always_comb begin
    tag_new      = tag_rd;
    stamp_new    = stamp_rd;
    tag_chg      = 1'b0;
    stamp_chg    = 1'b0;
    res_hit      = 1'b0;
    res_way      = '0;
    res_ev_valid = 1'b0;
    res_ev_addr  = '0;
    case (req_kind)
      REQ_LOOKUP: begin
        if (sel.hit) begin
          res_hit = 1'b1;
          res_way = sel.hit_way;
          if (sel.hit_way != '0) begin
            // Swap the hit entry into way 0
            tag_new[0]             = tag_rd[sel.hit_way];
            tag_new[sel.hit_way]   = tag_rd[0];
            stamp_new[0]           = req_time;
            stamp_new[sel.hit_way] = stamp_rd[0];
            tag_chg                = 1'b1;
            stamp_chg              = 1'b1;
          end
        end
      end
      REQ_ALLOC_LRU, REQ_ALLOC_RAND: begin
        res_way = (req_kind == REQ_ALLOC_LRU) ? sel.lru_way : PICK_ROM[req_pick];
        if (tag_rd[res_way].valid) begin
          res_ev_valid = 1'b1;
          res_ev_addr  = tag_rd[res_way].addr;
        end
        tag_new[res_way].valid = 1'b1;
        tag_new[res_way].addr  = req_addr;
        tag_chg                = 1'b1;
        if (req_kind == REQ_ALLOC_LRU) begin
          stamp_new[res_way] = req_time;
          stamp_chg          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM write port: clearing pass, or write-back when the result can move
  always_comb begin
    if (state == ST_CLEAR) begin
      tag_we      = 1'b1;
      stamp_we    = 1'b1;
      waddr       = clr_idx;
      tag_wdata   = '0;
      stamp_wdata = '0;
    end else begin
      tag_we      = (state == ST_EXEC) && done && tag_chg;
      stamp_we    = (state == ST_EXEC) && done && stamp_chg;
      waddr       = set_idx;
      tag_wdata   = tag_new;
      stamp_wdata = stamp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result, or drop the one taken by the receiver
      if (state == ST_EXEC && done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req_kind <= s_tuser;
            req_addr <= s_tdata[ADDR_W-1:0];
            req_time <= s_tdata[ADDR_W +: TIME_W];
            req_pick <= s_tdata[ADDR_W+TIME_W +: PICK_W];
            state    <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          quot  <= quot_next;
          state <= ST_SETI;
        end
        ST_SETI: begin
          set_idx <= set_calc;
          state   <= ST_EXEC;
        end
        ST_EXEC: begin
          // Hold until the output register is free
          if (done) begin
            m_tdata  <= {res_ev_addr, res_ev_valid, WAYOUT_W'(res_way)};
            m_tuser  <= res_hit;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sacts_checker.sv
// Port-level assertions for the tag store, bound to the top level
`default_nettype none

`include "set_assoc_cache_tag_store_assert.svh"

module sacts_checker
  import sacts_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  logic [40:0] out_word;
  logic        out_hit;
  logic        out_evict;

  assign out_word  = {m_tdata, m_tuser};
  assign out_hit   = m_tvalid && m_tuser[0];
  assign out_evict = m_tdata[8] || (m_tdata[39:9] != 31'd0);

  // A stalled result holds
  `SACTS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // One request in flight: no second accept right after one
  `SACTS_ASSERT_NEXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready)

  // A hit never reports an eviction
  `SACTS_ASSERT_IMP(a_hit_no_evict, clk, rst, out_hit, !out_evict)

  // Reported way stays inside the set
  `SACTS_ASSERT_IMP(a_way_range, clk, rst, m_tvalid, m_tdata[7:0] < 8'(WAYS))

  // Reset drops any result and starts the clearing pass
  `SACTS_ASSERT_NEXT_ALWAYS(a_reset, clk, rst, !m_tvalid && !s_tready)

endmodule

bind set_assoc_cache_tag_store sacts_checker u_sacts_checker (.*);

`default_nettype wire
